### rtl/vfps_pkg.sv
`timescale 1ns / 1ps
// Package for the voxel first-point seed selector.
// Holds sizes, hash constants, the state type and the key table types.
package vfps_pkg;

  localparam int MAX_SEED_LIMIT = 1024;
  localparam int TABLE_SLOTS    = 2048;
  localparam int KEY_BITS       = 24;
  localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
  localparam int EPOCH_BITS     = 8;
  localparam int COORD_W        = 32;
  localparam int INV_W          = 24;
  localparam int CNT_W          = 11;
  localparam int IDX_W          = 20;
  localparam int CFG_W          = 24;
  localparam int PROD_W         = COORD_W + INV_W + 1;
  localparam int QUOT_W         = PROD_W - 32;
  localparam int CALC_CYCLES    = 8;
  localparam int CALC_W         = $clog2(CALC_CYCLES + 1);

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(655360);
  localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(1024);

  localparam logic [31:0] HASH_MUL_X   = 32'h9E3779B1;
  localparam logic [31:0] HASH_MUL_Y   = 32'h85EBCA77;
  localparam logic [31:0] HASH_MUL_Z   = 32'hC2B2AE3D;
  localparam logic [31:0] HASH_MUL_MIX = 32'h27D4EB2D;

  localparam logic CFG_INV_VOXEL = 1'b0;
  localparam logic CFG_MAX_SEEDS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [KEY_BITS-1:0]   key_x;
    logic [KEY_BITS-1:0]   key_y;
    logic [KEY_BITS-1:0]   key_z;
  } entry_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    entry_t               data;
  } tbl_wr_t;

endpackage

### rtl/vfps_cell.sv
`timescale 1ns / 1ps
// One cell of the key and hash chain: turns one coordinate into a voxel key,
// multiplies it by its hash constant and folds it into the neighbor's hash. Uses vfps_pkg.
module vfps_cell (
  input  logic                           clk,
  input  logic signed [vfps_pkg::COORD_W-1:0] coord,
  input  logic [vfps_pkg::INV_W-1:0]     inv,
  input  logic [31:0]                    cmul,
  input  logic [31:0]                    acc_in,
  output logic [vfps_pkg::KEY_BITS-1:0]  key,
  output logic [31:0]                    acc_out
);
  import vfps_pkg::*;

  localparam logic signed [QUOT_W-1:0] KMAX = QUOT_W'((1 << (KEY_BITS - 1)) - 1);
  localparam logic signed [QUOT_W-1:0] KMIN = -KMAX - QUOT_W'(1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [QUOT_W-1:0] quot;
  logic [KEY_BITS-1:0]      key_r;
  logic [31:0]              key_ext;
  logic [31:0]              kmul_r;
  logic [31:0]              acc_r;

  // Floor of the product over 2^32 is the arithmetic upper slice.
  assign quot    = prod_r[PROD_W-1:32];
  assign key_ext = 32'(signed'(key_r));

  always_ff @(posedge clk) begin
    prod_r <= coord * $signed({1'b0, inv});
    if (quot > KMAX) begin
      key_r <= KMAX[KEY_BITS-1:0];
    end else if (quot < KMIN) begin
      key_r <= KMIN[KEY_BITS-1:0];
    end else begin
      key_r <= quot[KEY_BITS-1:0];
    end
    kmul_r <= key_ext * cmul;
    acc_r  <= acc_in ^ kmul_r;
  end

  assign key     = key_r;
  assign acc_out = acc_r;

endmodule

### rtl/vfps_table.sv
`timescale 1ns / 1ps
// Key table of the seed selector: one write port and one registered read port.
// Each entry holds a voxel key and the frame epoch it was written in. Uses vfps_pkg.
module vfps_table (
  input  logic                           clk,
  input  vfps_pkg::tbl_wr_t              wr,
  input  logic                           rd_en,
  input  logic [vfps_pkg::SLOT_BITS-1:0] rd_addr,
  output vfps_pkg::entry_t               rd_data
);
  import vfps_pkg::*;

  entry_t mem [TABLE_SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/voxel_first_point_seed_select.sv
`timescale 1ns / 1ps
// Voxel first-point seed selector. Each point is accepted, then passes through the chain
// of three key cells and the hash multiplier, then through table probes (each a read, then
// a compare), and a point that finds a free slot loads the result register, waiting while
// the result register stays stalled; a point that is dropped at once (not finite, or the
// frame is closed) goes straight back to idle. No new point is taken until the last one is
// done. Probes go one at a time through the key table's single read port.
// After reset, and on every 255th frame start, all 2048 table slots are swept to
// clear their epoch marks while no point is taken.
module voxel_first_point_seed_select (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [vfps_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vfps_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [vfps_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [vfps_pkg::COORD_W-1:0] in_point_z,
  input  logic [vfps_pkg::IDX_W-1:0]          in_point_index,
  input  logic                                in_point_finite,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vfps_pkg::IDX_W-1:0]          out_seed_index,
  output logic [vfps_pkg::CNT_W-1:0]          out_seed_count,
  output logic                                out_limit_reached
);
  import vfps_pkg::*;

  localparam int SEED_CAP = (MAX_SEED_LIMIT < TABLE_SLOTS) ? MAX_SEED_LIMIT : TABLE_SLOTS;
  localparam logic [CNT_W-1:0] CAP_MAX  = CNT_W'(SEED_CAP);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

  state_t                  state_r, state_nxt;
  logic [INV_W-1:0]        inv_r;
  logic [CNT_W-1:0]        max_r;
  logic [CNT_W-1:0]        lim;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    closed_r, closed_nxt;
  logic [EPOCH_BITS-1:0]   epoch_r, epoch_nxt;
  logic                    pend_r, pend_nxt;
  logic [SLOT_BITS-1:0]    clr_r, clr_nxt;
  logic [CALC_W-1:0]       calc_r, calc_nxt;
  logic [SLOT_BITS-1:0]    slot_r, slot_nxt;
  logic [SLOT_BITS:0]      probe_r, probe_nxt;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                    out_lim_r, out_lim_nxt;
  logic [KEY_BITS-1:0]     kx, ky, kz;
  logic [31:0]             acc0, acc1, acc2;
  logic [31:0]             mix;
  logic [31:0]             hm_r;
  logic [31:0]             fin;
  tbl_wr_t                 wr;
  logic                    rd_en;
  entry_t                  rd_data;
  logic                    accept;
  logic [CNT_W-1:0]        cnt_acc;
  logic                    closed_acc;
  logic                    go;

  always_comb begin
    lim = (max_r == '0) ? CNT_W'(1) : max_r;
    if (lim > CAP_MAX) begin
      lim = CAP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_RESET;
      max_r <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_VOXEL: inv_r <= cfg_wdata[INV_W-1:0];
        CFG_MAX_SEEDS: max_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  vfps_cell u_cell_x (
    .clk(clk), .coord(px_r), .inv(inv_r), .cmul(HASH_MUL_X),
    .acc_in(32'd0), .key(kx), .acc_out(acc0)
  );
  vfps_cell u_cell_y (
    .clk(clk), .coord(py_r), .inv(inv_r), .cmul(HASH_MUL_Y),
    .acc_in(acc0), .key(ky), .acc_out(acc1)
  );
  vfps_cell u_cell_z (
    .clk(clk), .coord(pz_r), .inv(inv_r), .cmul(HASH_MUL_Z),
    .acc_in(acc1), .key(kz), .acc_out(acc2)
  );

  assign mix = acc2 ^ (acc2 >> 15);
  assign fin = hm_r ^ (hm_r >> 13);

  always_ff @(posedge clk) begin
    hm_r <= mix * HASH_MUL_MIX;
  end

  vfps_table u_table (
    .clk(clk), .wr(wr), .rd_en(rd_en), .rd_addr(slot_r), .rd_data(rd_data)
  );

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      pz_r  <= in_point_z;
      idx_r <= in_point_index;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    closed_nxt    = closed_r;
    epoch_nxt     = epoch_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    calc_nxt      = calc_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_lim_nxt   = out_lim_r;
    wr            = '0;
    rd_en         = 1'b0;
    cnt_acc       = in_frame_start ? '0 : cnt_r;
    closed_acc    = in_frame_start ? 1'b0 : closed_r;
    go            = in_point_finite && !closed_acc && (cnt_acc < lim);
    case (state_r)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        clr_nxt = clr_r + SLOT_BITS'(1);
        if (clr_r == SLOT_BITS'(TABLE_SLOTS - 1)) begin
          epoch_nxt = EPOCH_BITS'(1);
          pend_nxt  = 1'b0;
          calc_nxt  = '0;
          state_nxt = pend_r ? ST_CALC : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt    = cnt_acc;
          closed_nxt = closed_acc;
          calc_nxt   = '0;
          if (in_frame_start && epoch_r == EPOCH_LAST) begin
            pend_nxt  = go;
            state_nxt = ST_CLEAR;
          end else begin
            if (in_frame_start) begin
              epoch_nxt = epoch_r + EPOCH_BITS'(1);
            end
            state_nxt = go ? ST_CALC : ST_IDLE;
          end
        end
      end
      ST_CALC: begin
        calc_nxt = calc_r + CALC_W'(1);
        if (calc_r == CALC_W'(CALC_CYCLES - 1)) begin
          slot_nxt  = fin[SLOT_BITS-1:0];
          probe_nxt = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rd_data.epoch != epoch_r) begin
          wr.en         = 1'b1;
          wr.addr       = slot_r;
          wr.data.epoch = epoch_r;
          wr.data.key_x = kx;
          wr.data.key_y = ky;
          wr.data.key_z = kz;
          cnt_nxt       = cnt_r + CNT_W'(1);
          closed_nxt    = (cnt_nxt >= lim);
          state_nxt     = ST_EMIT;
        end else if (rd_data.key_x == kx && rd_data.key_y == ky && rd_data.key_z == kz) begin
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt  = slot_r + SLOT_BITS'(1);
          probe_nxt = probe_r + (SLOT_BITS+1)'(1);
          state_nxt = (probe_nxt == (SLOT_BITS+1)'(TABLE_SLOTS)) ? ST_IDLE : ST_READ;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_cnt_nxt   = cnt_r;
          out_lim_nxt   = closed_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      closed_r    <= 1'b0;
      epoch_r     <= '0;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      calc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      epoch_r     <= epoch_nxt;
      pend_r      <= pend_nxt;
      clr_r       <= clr_nxt;
      calc_r      <= calc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    probe_r   <= probe_nxt;
    out_idx_r <= out_idx_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_lim_r <= out_lim_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_seed_index    = out_idx_r;
  assign out_seed_count    = out_cnt_r;
  assign out_limit_reached = out_lim_r;

`ifndef SYNTHESIS
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("Result appeared without passing the emit state.");
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seed_count != '0 && out_seed_count <= lim))
    else $error("Seed count outside the seed limit.");
  a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limit_reached) |-> (out_seed_count >= lim))
    else $error("Limit flag set below the seed limit.");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_CMP) |-> in_stall)
    else $error("Input taken while the table is busy.");
`endif

endmodule
